// ===== rtl/core/tptc_pkg.sv =====
// Shared types and constants for the TCP port traffic counter.
`default_nettype none
package tptc_pkg;

  localparam logic [15:0] KIND_IPV4   = 16'h0800;
  localparam logic [15:0] KIND_IPV6   = 16'h86DD;
  localparam logic [7:0]  PROTO_TCP   = 8'd6;
  localparam logic [15:0] FRAG_MF     = 16'h2000;
  localparam logic [15:0] FRAG_OFFSET = 16'h1FFF;
  localparam logic [15:0] PORT_RESET  = 16'd8080;
  localparam int          WORD_BYTES  = 4;
  localparam logic [15:0] POS_MAX     = 16'hFFFF;

  // Frame byte offsets
  localparam logic [15:0] POS_TYPE_HI  = 16'd12;
  localparam logic [15:0] POS_TYPE_LO  = 16'd13;
  localparam logic [15:0] POS_L3       = 16'd14;
  localparam logic [15:0] POS_V4_FRAG  = 16'd20;
  localparam logic [15:0] POS_V4_FRAG2 = 16'd21;
  localparam logic [15:0] POS_V4_PROTO = 16'd23;
  localparam logic [15:0] POS_V6_NEXT  = 16'd20;
  localparam logic [15:0] POS_V6_PORT  = 16'd56;
  localparam int          V4_PORT_BASE = 16;
  localparam int          V4_MIN_LEN   = 34;
  localparam int          V6_MIN_LEN   = 74;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic        counted;
    logic [63:0] total_bytes;
    logic [63:0] total_packets;
  } out_beat_t;

  // Per-frame verdict handed from parser to counters
  typedef struct packed {
    logic        hit;
    logic [15:0] len;
  } frame_sum_t;

endpackage
`default_nettype wire

// ===== rtl/core/tcp_port_traffic_counter.sv =====
// Top level: TCP destination port traffic counter.
//
//   channel     dir  handshake            payload
//   in          in   in_valid/in_ready    in_data    (data_byte, last_byte)
//   out         out  out_valid/out_ready  out_data   (counted, total_bytes, total_packets)
//   match_port  in   match_port_we        match_port_wdata
//
// One byte beat per cycle is taken while in_ready is high; each frame yields one result beat on its last byte.
// A result passes from the parser through the verdict queue to the counter register.
// The verdict queue (QUEUE_DEPTH entries) absorbs output stalls; in_ready drops when it fills.
// Synchronous reset clears parser state, queue and totals and sets match_port to 8080.
`default_nettype none
module tcp_port_traffic_counter #(
  parameter int QUEUE_DEPTH = tptc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire tptc_pkg::in_beat_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output tptc_pkg::out_beat_t       out_data,
  input  wire logic                 match_port_we,
  input  wire logic [15:0]          match_port_wdata
);
  import tptc_pkg::*;

  logic       beat_take;
  logic       q_full;
  logic       q_not_empty;
  logic       q_pop;
  frame_sum_t front_sum;
  frame_sum_t back_sum;

  assign in_ready  = !q_full;
  assign beat_take = in_valid && in_ready;

  tptc_front u_front (
    .clk              (clk),
    .rst              (rst),
    .match_port_we    (match_port_we),
    .match_port_wdata (match_port_wdata),
    .beat_take        (beat_take),
    .beat             (in_data),
    .sum              (front_sum)
  );

  tptc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (beat_take && in_data.last_byte),
    .push_data (front_sum),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .pop_data  (back_sum)
  );

  tptc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .sum_valid (q_not_empty),
    .sum       (back_sum),
    .sum_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/core/tptc_front.sv =====
// Frame parser: tracks header fields byte by byte and emits a verdict per frame.
`default_nettype none
module tptc_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 match_port_we,
  input  wire logic [15:0]          match_port_wdata,
  input  wire logic                 beat_take,
  input  wire tptc_pkg::in_beat_t   beat,
  output tptc_pkg::frame_sum_t      sum
);
  import tptc_pkg::*;

  logic [15:0] match_port;
  logic [15:0] pos;
  logic [15:0] kind;
  logic [3:0]  ihl;
  logic        frag;
  logic [7:0]  proto;
  logic [15:0] port;

  logic [15:0] kind_next;
  logic [3:0]  ihl_next;
  logic        frag_next;
  logic [7:0]  proto_next;
  logic [15:0] port_next;
  logic [15:0] len;
  logic        is_v4;
  logic        is_v6;
  logic        in_l3;
  logic [6:0]  port_at;
  logic [6:0]  v4_min;
  logic [7:0]  b;

  assign b = beat.data_byte;

  always_comb begin
    kind_next = kind;
    if (pos == POS_TYPE_HI || pos == POS_TYPE_LO) begin
      kind_next = {kind[7:0], b};
    end
    is_v4 = (kind_next == KIND_IPV4);
    is_v6 = (kind_next == KIND_IPV6);
    in_l3 = (pos >= POS_L3);

    ihl_next   = ihl;
    frag_next  = frag;
    proto_next = proto;
    port_next  = port;
    if (is_v4 && in_l3) begin
      if (pos == POS_L3) begin
        ihl_next = b[3:0];
      end
      if (pos == POS_V4_FRAG && (({b, 8'h00} & (FRAG_MF | FRAG_OFFSET)) != 16'd0)) begin
        frag_next = 1'b1;
      end
      if (pos == POS_V4_FRAG2 && b != 8'd0) begin
        frag_next = 1'b1;
      end
      if (pos == POS_V4_PROTO) begin
        proto_next = b;
      end
    end else if (is_v6 && in_l3) begin
      if (pos == POS_V6_NEXT) begin
        proto_next = b;
      end
    end

    // TCP dest port sits 16 + 4*IHL bytes in for IPv4
    port_at = 7'(V4_PORT_BASE) + 7'(WORD_BYTES) * {3'd0, ihl_next};
    v4_min  = 7'(V4_MIN_LEN) + 7'(WORD_BYTES) * {3'd0, ihl_next};
    if (is_v4 && in_l3) begin
      if (pos == {9'd0, port_at} || pos == {9'd0, port_at} + 16'd1) begin
        port_next = {port[7:0], b};
      end
    end else if (is_v6 && in_l3) begin
      if (pos == POS_V6_PORT || pos == POS_V6_PORT + 16'd1) begin
        port_next = {port[7:0], b};
      end
    end

    len = (pos != POS_MAX) ? pos + 16'd1 : POS_MAX;

    sum.len = len;
    sum.hit = 1'b0;
    if (is_v4) begin
      sum.hit = (len >= 16'(V4_MIN_LEN)) && (len >= {9'd0, v4_min}) && !frag_next &&
                (proto_next == PROTO_TCP) && (port_next == match_port);
    end else if (is_v6) begin
      sum.hit = (len >= 16'(V6_MIN_LEN)) && (proto_next == PROTO_TCP) &&
                (port_next == match_port);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_port <= PORT_RESET;
      pos        <= '0;
      kind       <= '0;
      ihl        <= '0;
      frag       <= 1'b0;
      proto      <= '0;
      port       <= '0;
    end else begin
      if (match_port_we) begin
        match_port <= match_port_wdata;
      end
      if (beat_take) begin
        if (beat.last_byte) begin
          pos   <= '0;
          kind  <= '0;
          ihl   <= '0;
          frag  <= 1'b0;
          proto <= '0;
          port  <= '0;
        end else begin
          pos   <= len;
          kind  <= kind_next;
          ihl   <= ihl_next;
          frag  <= frag_next;
          proto <= proto_next;
          port  <= port_next;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tptc_queue.sv =====
// Small register FIFO of frame verdicts between parser and counters.
`default_nettype none
module tptc_queue #(
  parameter int DEPTH = tptc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire tptc_pkg::frame_sum_t  push_data,
  output logic                       full,
  output logic                       not_empty,
  input  wire logic                  pop,
  output tptc_pkg::frame_sum_t       pop_data
);
  import tptc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_sum_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tptc_back.sv =====
// Counter stage: applies frame verdicts to the totals and holds the result beat.
`default_nettype none
module tptc_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  sum_valid,
  input  wire tptc_pkg::frame_sum_t  sum,
  output logic                       sum_pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output tptc_pkg::out_beat_t        out_data
);
  import tptc_pkg::*;

  logic        counted;
  logic [63:0] byte_total;
  logic [63:0] packet_total;

  // Totals only move when a new result is loaded, so they double as payload
  assign sum_pop = sum_valid && (!out_valid || out_ready);

  assign out_data.counted       = counted;
  assign out_data.total_bytes   = byte_total;
  assign out_data.total_packets = packet_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      counted      <= 1'b0;
      byte_total   <= '0;
      packet_total <= '0;
    end else begin
      if (sum_pop) begin
        out_valid <= 1'b1;
        counted   <= sum.hit;
        if (sum.hit) begin
          byte_total   <= byte_total + {48'd0, sum.len};
          packet_total <= packet_total + 64'd1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== bench/tptc_tally_check.sv =====
// Scoreboard for the TCP port traffic counter: follows the byte stream and checks result beats.
module tptc_tally_check (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire tptc_pkg::in_beat_t  in_data,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire tptc_pkg::out_beat_t out_data,
  input  wire logic                match_port_we,
  input  wire logic [15:0]         match_port_wdata,
  output int                       errors,
  output int                       pending
);
  import tptc_pkg::*;

  logic [15:0] port_cfg;
  logic [15:0] frame_pos;
  logic [15:0] eth_type;
  logic [3:0]  ihl;
  logic        frag_hit;
  logic [7:0]  l4_proto;
  logic [15:0] dst_port;
  logic [63:0] byte_sum;
  logic [63:0] pkt_sum;

  out_beat_t tally_due[$];
  out_beat_t due;

  task automatic clear_frame();
    frame_pos = '0;
    eth_type  = '0;
    ihl       = '0;
    frag_hit  = 1'b0;
    l4_proto  = '0;
    dst_port  = '0;
  endtask

  // Walks one byte through the header parse; on the last byte queues the expected beat.
  task automatic parse_frame_byte(input in_beat_t beat);
    int        pos;
    int        len;
    int        port_at;
    logic      hit;
    out_beat_t res;
    pos = frame_pos;
    hit = 1'b0;
    if (pos == POS_TYPE_HI || pos == POS_TYPE_LO)
      eth_type = {eth_type[7:0], beat.data_byte};

    if (eth_type == KIND_IPV4 && pos >= POS_L3) begin
      if (pos == POS_L3)
        ihl = beat.data_byte[3:0];
      // DF and the reserved bit do not mark a fragment
      if (pos == POS_V4_FRAG && ({beat.data_byte, 8'h00} & (FRAG_MF | FRAG_OFFSET)) != 16'h0)
        frag_hit = 1'b1;
      if (pos == POS_V4_FRAG2 && beat.data_byte != 8'h00)
        frag_hit = 1'b1;
      if (pos == POS_V4_PROTO)
        l4_proto = beat.data_byte;
      port_at = V4_PORT_BASE + WORD_BYTES * int'(ihl);
      if (pos == port_at || pos == port_at + 1)
        dst_port = {dst_port[7:0], beat.data_byte};
    end else if (eth_type == KIND_IPV6 && pos >= POS_L3) begin
      if (pos == POS_V6_NEXT)
        l4_proto = beat.data_byte;
      if (pos == POS_V6_PORT || pos == POS_V6_PORT + 1)
        dst_port = {dst_port[7:0], beat.data_byte};
    end

    len = (pos < int'(POS_MAX)) ? pos + 1 : int'(POS_MAX);

    if (!beat.last_byte) begin
      frame_pos = len[15:0];
    end else begin
      if (eth_type == KIND_IPV4) begin
        hit = len >= V4_MIN_LEN && len >= V4_MIN_LEN + WORD_BYTES * int'(ihl) &&
              !frag_hit && l4_proto == PROTO_TCP && dst_port == port_cfg;
      end else if (eth_type == KIND_IPV6) begin
        hit = len >= V6_MIN_LEN && l4_proto == PROTO_TCP && dst_port == port_cfg;
      end
      if (hit) begin
        byte_sum = byte_sum + 64'(len);
        pkt_sum  = pkt_sum + 64'd1;
      end
      res.counted       = hit;
      res.total_bytes   = byte_sum;
      res.total_packets = pkt_sum;
      tally_due.push_back(res);
      clear_frame();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      port_cfg = PORT_RESET;
      clear_frame();
      byte_sum = '0;
      pkt_sum  = '0;
      tally_due.delete();
      errors = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (tally_due.size() == 0) begin
          $error("result beat with no frame pending: counted %0d bytes %0d packets %0d",
                 out_data.counted, out_data.total_bytes, out_data.total_packets);
          errors++;
        end else begin
          due = tally_due.pop_front();
          if (out_data.counted !== due.counted) begin
            $error("counted: expected %0d, got %0d", due.counted, out_data.counted);
            errors++;
          end
          if (out_data.total_bytes !== due.total_bytes) begin
            $error("total_bytes: expected %0d, got %0d", due.total_bytes, out_data.total_bytes);
            errors++;
          end
          if (out_data.total_packets !== due.total_packets) begin
            $error("total_packets: expected %0d, got %0d",
                   due.total_packets, out_data.total_packets);
            errors++;
          end
        end
      end
      if (in_valid && in_ready)
        parse_frame_byte(in_data);
      if (match_port_we)
        port_cfg = match_port_wdata;
    end
    pending = tally_due.size();
  end

endmodule

// ===== bench/tb_tcp_port_traffic_counter.sv =====
// Testbench top for the TCP port traffic counter: frame stimulus, output stalls and verdict.
module tb_tcp_port_traffic_counter;
  import tptc_pkg::*;

  localparam int IDLE_LIMIT   = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_BYTES  = 40;
  localparam int PHASE_FRAMES = 1;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_beat_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_beat_t   out_data;
  logic        match_port_we;
  logic [15:0] match_port_wdata;

  int errors;
  int pending;
  int idle_run;
  int burst_left;
  int stall_asks;
  int stall_done;
  int phase_bytes;
  int phase_frames;

  logic [15:0] cur_port;
  logic [7:0]  frame_buf[$];

  tcp_port_traffic_counter dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data),
    .match_port_we    (match_port_we),
    .match_port_wdata (match_port_wdata)
  );

  tptc_tally_check tally_check (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data),
    .match_port_we    (match_port_we),
    .match_port_wdata (match_port_wdata),
    .errors           (errors),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: too long without any beat or register write means a hang.
  initial idle_run = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || match_port_we) begin
      idle_run <= 0;
    end else if (idle_run >= IDLE_LIMIT) begin
      $display("tb_tcp_port_traffic_counter: FAIL");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // Receiver: segments of differing ready density, plus a long hold-off on request.
  initial begin
    int seg;
    int mode;
    out_ready  = 1'b0;
    stall_done = 0;
    forever begin
      seg  = $urandom_range(10, 120);
      mode = $urandom_range(0, 3);
      repeat (seg) begin
        @(posedge clk);
        if (stall_asks != stall_done) begin
          stall_done = stall_asks;
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // One byte beat; bursts of random length separated by random gaps.
  task automatic send_beat(input logic [7:0] d, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300)
                                               : $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= {d, last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    phase_bytes++;
  endtask

  task automatic send_frame();
    foreach (frame_buf[i])
      send_beat(frame_buf[i], i == frame_buf.size() - 1);
    phase_frames++;
  endtask

  // fill: 0 random, 1 all zero, 2 all ones
  task automatic fill_bytes(input int len, input int fill);
    frame_buf.delete();
    repeat (len) begin
      case (fill)
        1: frame_buf.push_back(8'h00);
        2: frame_buf.push_back(8'hFF);
        default: frame_buf.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic put(input int idx, input logic [7:0] val);
    if (idx < frame_buf.size())
      frame_buf[idx] = val;
  endtask

  task automatic make_v4(input int len, input logic [3:0] hl, input logic [15:0] port,
                         input logic [7:0] proto, input logic [15:0] frag);
    fill_bytes(len, 0);
    put(POS_TYPE_HI, KIND_IPV4[15:8]);
    put(POS_TYPE_LO, KIND_IPV4[7:0]);
    // keep the version nibble random
    if (len > POS_L3)
      frame_buf[POS_L3][3:0] = hl;
    put(POS_V4_FRAG, frag[15:8]);
    put(POS_V4_FRAG2, frag[7:0]);
    put(POS_V4_PROTO, proto);
    put(V4_PORT_BASE + WORD_BYTES * int'(hl), port[15:8]);
    put(V4_PORT_BASE + WORD_BYTES * int'(hl) + 1, port[7:0]);
  endtask

  task automatic make_v6(input int len, input logic [15:0] port, input logic [7:0] proto);
    fill_bytes(len, 0);
    put(POS_TYPE_HI, KIND_IPV6[15:8]);
    put(POS_TYPE_LO, KIND_IPV6[7:0]);
    put(POS_V6_NEXT, proto);
    put(POS_V6_PORT, port[15:8]);
    put(POS_V6_PORT + 1, port[7:0]);
  endtask

  task automatic rand_frame();
    int          pick;
    int          hl;
    int          need;
    int          len;
    logic [15:0] port;
    logic [7:0]  proto;
    logic [15:0] frag;
    pick  = $urandom_range(0, 99);
    port  = ($urandom_range(0, 3) != 0) ? cur_port : 16'($urandom_range(0, 65535));
    proto = ($urandom_range(0, 9) != 0) ? PROTO_TCP : 8'($urandom_range(0, 255));
    if (pick < 45) begin
      hl   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 15);
      need = V4_MIN_LEN + WORD_BYTES * hl;
      len  = ($urandom_range(0, 4) != 0) ? need + $urandom_range(0, 30)
                                         : $urandom_range(15, need - 1);
      case ($urandom_range(0, 9))
        0: frag = FRAG_MF;
        1: frag = 16'($urandom_range(0, 65535));
        2: frag = 16'h4000;
        default: frag = 16'h0000;
      endcase
      make_v4(len, 4'(hl), port, proto, frag);
    end else if (pick < 80) begin
      len = ($urandom_range(0, 4) != 0) ? V6_MIN_LEN + $urandom_range(0, 30)
                                        : $urandom_range(21, V6_MIN_LEN - 1);
      make_v6(len, port, proto);
    end else if (pick < 90) begin
      fill_bytes($urandom_range(1, 80), 0);
    end else begin
      fill_bytes($urandom_range(1, 16), 0);
    end
    send_frame();
  endtask

  // Block is idle once every result is back and the pipeline has drained.
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_port(input logic [15:0] p);
    wait_idle();
    match_port_we    <= 1'b1;
    match_port_wdata <= p;
    @(posedge clk);
    match_port_we <= 1'b0;
    cur_port = p;
  endtask

  task automatic random_phase();
    phase_bytes  = 0;
    phase_frames = 0;
    while (phase_bytes < PHASE_BYTES || phase_frames < PHASE_FRAMES)
      rand_frame();
  endtask

  initial begin
    in_valid         = 1'b0;
    in_data          = '0;
    match_port_we    = 1'b0;
    match_port_wdata = '0;
    rst              = 1'b1;
    burst_left       = 0;
    stall_asks       = 0;
    cur_port         = PORT_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed frames against the reset port
    make_v4(54, 4'd5, cur_port, PROTO_TCP, 16'h0000);  send_frame();
    make_v4(53, 4'd5, cur_port, PROTO_TCP, 16'h0000);  send_frame();
    make_v4(60, 4'd5, cur_port ^ 16'h1, PROTO_TCP, 16'h0000); send_frame();
    make_v4(54, 4'd5, cur_port, PROTO_TCP, FRAG_MF);   send_frame();
    make_v4(54, 4'd5, cur_port, PROTO_TCP, 16'h0001);  send_frame();
    make_v4(54, 4'd5, cur_port, PROTO_TCP, 16'h1000);  send_frame();
    make_v4(54, 4'd5, cur_port, PROTO_TCP, 16'hC000);  send_frame();
    make_v4(54, 4'd5, cur_port, 8'd17, 16'h0000);      send_frame();
    make_v4(94, 4'd15, cur_port, PROTO_TCP, 16'h0000); send_frame();
    make_v4(93, 4'd15, cur_port, PROTO_TCP, 16'h0000); send_frame();
    // IHL of zero puts the port over the IPv4 total length field (bytes 16 and 17)
    make_v4(34, 4'd0, cur_port, PROTO_TCP, 16'h0000);  send_frame();
    // IHL of one puts the port over the flags word
    make_v4(40, 4'd1, cur_port, PROTO_TCP, 16'h0000);  send_frame();
    make_v6(74, cur_port, PROTO_TCP);                  send_frame();
    make_v6(73, cur_port, PROTO_TCP);                  send_frame();
    make_v6(90, cur_port, 8'd17);                      send_frame();
    make_v4(60, 4'd5, cur_port, PROTO_TCP, 16'h0000);
    frame_buf[POS_TYPE_LO] = 8'h06;                    send_frame();
    fill_bytes(1, 0);                                  send_frame();
    fill_bytes(13, 2);                                 send_frame();
    fill_bytes(60, 1);                                 send_frame();

    set_port(16'h0000);
    random_phase();

    set_port(16'hFFFF);
    // long output hold while short frames keep coming: fills the verdict queue
    stall_asks++;
    repeat (12) begin
      fill_bytes($urandom_range(1, 4), 0);
      send_frame();
    end
    random_phase();

    set_port(16'($urandom_range(0, 65535)));
    random_phase();

    set_port(PORT_RESET);
    random_phase();
    make_v6(80, cur_port, PROTO_TCP);
    send_frame();

    wait_idle();
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("tb_tcp_port_traffic_counter: PASS");
    else
      $display("tb_tcp_port_traffic_counter: FAIL");
    $finish;
  end

endmodule
